[src/lru_pkg.sv]
`default_nettype none

package lru_pkg;

    localparam int TRACKED_KEYS = 16;
    localparam int KEY_W        = 4;
    localparam int CNT_W        = $clog2(TRACKED_KEYS + 1);

    localparam logic [1:0] ACT_TOUCH = 2'd0;
    localparam logic [1:0] ACT_EVICT = 2'd1;
    localparam logic [1:0] ACT_ERASE = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] victim_key;
        logic [CNT_W-1:0] tracked_count;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_APPEND
    } t_state;

endpackage

`default_nettype wire

[src/lru_replacement_tracker.sv]
`default_nettype none

// LRU replacement tracker. Holds the set of frame indices that may be
// evicted, ordered by recency of use. A command word (touch, evict, erase)
// is taken when start is high and busy is low; exactly one result word
// follows on o_res, flagged by o_done for a single cycle. The
// receiver cannot stall, so the word must be captured in that cycle. The
// order is kept as a doubly linked list over keys: two 16-entry link
// memories (previous and next key), each with a registered read, plus
// head and tail registers and a flag per key. The link memories are read
// once as the command is taken; the update writes them back. Evict and
// erase finish in the update state; touch goes on to an append state
// that links the key at the most-recent end. A new command may be issued in
// the cycle that o_done is high. The link memories need no clearing after
// reset: only linked entries are ever followed.
module lru_replacement_tracker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lru_pkg::t_cmd i_cmd,
    output logic               o_done,
    output lru_pkg::t_res      o_res
);
    import lru_pkg::*;

    // link memories, indexed by key
    logic [KEY_W-1:0] r_prv_mem [TRACKED_KEYS];
    logic [KEY_W-1:0] r_nxt_mem [TRACKED_KEYS];
    logic [KEY_W-1:0] r_prv_q;
    logic [KEY_W-1:0] r_nxt_q;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    logic [KEY_W-1:0]        r_head, n_head;
    logic [KEY_W-1:0]        r_tail, n_tail;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [TRACKED_KEYS-1:0] r_tracked, n_tracked;
    t_res                    r_res, n_res;
    logic                    r_done, n_done;

    logic             accept;
    logic [KEY_W-1:0] rd_addr;
    logic             prv_we, nxt_we;
    logic [KEY_W-1:0] prv_waddr, nxt_waddr;
    logic [KEY_W-1:0] prv_wdata, nxt_wdata;
    logic             is_head, is_tail;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    // evict follows the head; touch and erase look up the key itself
    assign rd_addr = (i_cmd.action == ACT_EVICT) ? r_head : i_cmd.key;
    assign is_head = (r_head == r_cmd.key);
    assign is_tail = (r_tail == r_cmd.key);

    // link memory ports
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prv_q <= r_prv_mem[rd_addr];
            r_nxt_q <= r_nxt_mem[rd_addr];
        end
        if (prv_we) begin
            r_prv_mem[prv_waddr] <= prv_wdata;
        end
        if (nxt_we) begin
            r_nxt_mem[nxt_waddr] <= nxt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_tracked <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_tracked <= n_tracked;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_head <= n_head;
        r_tail <= n_tail;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_tracked = r_tracked;
        n_res     = r_res;
        n_done    = 1'b0;
        prv_we    = 1'b0;
        nxt_we    = 1'b0;
        prv_waddr = r_cmd.key;
        nxt_waddr = r_prv_q;
        prv_wdata = r_prv_q;
        nxt_wdata = r_nxt_q;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                n_res.ok         = 1'b0;
                n_res.victim_key = '0;
                n_state          = ST_IDLE;
                n_done           = 1'b1;
                case (r_cmd.action)
                    ACT_TOUCH, ACT_ERASE: begin
                        if (r_tracked[r_cmd.key]) begin
                            // unlink the key: bridge its neighbours
                            if (is_head) begin
                                n_head = r_nxt_q;
                            end else begin
                                nxt_we    = 1'b1;
                                nxt_waddr = r_prv_q;
                                nxt_wdata = r_nxt_q;
                            end
                            if (is_tail) begin
                                n_tail = r_prv_q;
                            end else begin
                                prv_we    = 1'b1;
                                prv_waddr = r_nxt_q;
                                prv_wdata = r_prv_q;
                            end
                            n_count = r_count - CNT_W'(1);
                            n_tracked[r_cmd.key] = 1'b0;
                            n_res.ok = 1'b1;
                        end
                        if (r_cmd.action == ACT_TOUCH) begin
                            n_state = ST_APPEND;
                            n_done  = 1'b0;
                        end
                    end
                    ACT_EVICT: begin
                        if (r_count != '0) begin
                            n_head           = r_nxt_q;
                            n_count          = r_count - CNT_W'(1);
                            n_tracked[r_head] = 1'b0;
                            n_res.ok         = 1'b1;
                            n_res.victim_key = r_head;
                        end
                    end
                    default: begin
                        // unused code: no change
                    end
                endcase
                n_res.tracked_count = n_count;
            end

            ST_APPEND: begin
                // link the key in at the most-recent end
                if (r_count == '0) begin
                    n_head = r_cmd.key;
                end else begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_tail;
                    nxt_wdata = r_cmd.key;
                    prv_we    = 1'b1;
                    prv_waddr = r_cmd.key;
                    prv_wdata = r_tail;
                end
                n_tail               = r_cmd.key;
                n_count              = r_count + CNT_W'(1);
                n_tracked[r_cmd.key] = 1'b1;
                n_res.ok             = 1'b1;
                n_res.victim_key     = '0;
                n_res.tracked_count  = n_count;
                n_state              = ST_IDLE;
                n_done               = 1'b1;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // count never passes the key range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TRACKED_KEYS))
        else $error("tracked count out of range");

    // between commands the flags and the count agree
    a_flags_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_tracked) == 32'(r_count)))
        else $error("tracked flags disagree with count");

    // a result only ever closes a command in progress
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a command");

    // an evicted key is no longer tracked
    a_victim_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.ok && r_cmd.action == ACT_EVICT)
            |-> !r_tracked[o_res.victim_key])
        else $error("victim still tracked");

    // a successful touch leaves the key tracked at the tail
    a_touch_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_cmd.action == ACT_TOUCH)
            |-> (r_tracked[r_cmd.key] && r_tail == r_cmd.key))
        else $error("touched key not at most-recent end");

endmodule

`default_nettype wire

[dv/lru_replacement_tracker_test.sv]
module lru_replacement_tracker_test;

    import lru_pkg::*;

    // Action code 3 has no name in the package; the tracker must answer it
    // with ok 0, victim 0 and leave its state alone.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Random section: roughly this many command words after the directed list.
    localparam int RANDOM_WORDS = 1200;

    // Weightings for the random section. Fill runs push the tracker to a full
    // set of 16 keys, drain runs empty it again, mixed runs sit in between.
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_BLEND = 2;

    // ------------------------------------------------------------------
    // Scoreboard: holds its own copy of the recency order, oldest key at
    // the front of the queue, plus a tracked flag per key. Each accepted
    // command word yields exactly one expected result word.
    // ------------------------------------------------------------------
    class lru_order_scoreboard;
        logic [KEY_W-1:0] recency[$];
        bit   [TRACKED_KEYS-1:0] tracked;
        t_res awaited[$];
        int   mismatches;

        function new();
            recency.delete();
            tracked    = '0;
            mismatches = 0;
        endfunction

        // Drop a key from wherever it sits; later keys close up towards
        // the least-recent end.
        function void unlink_key(logic [KEY_W-1:0] k);
            int pos;
            pos = -1;
            foreach (recency[i])
                if (pos < 0 && recency[i] == k)
                    pos = i;
            if (pos >= 0)
                recency.delete(pos);
        endfunction

        // Work out the result word for an accepted command word.
        function void note_cmd(t_cmd c);
            t_res r;
            r = '0;
            case (c.action)
                ACT_TOUCH: begin
                    // touching a tracked key moves it; count stays put
                    if (tracked[c.key])
                        unlink_key(c.key);
                    if (recency.size() < TRACKED_KEYS) begin
                        recency.push_back(c.key);
                        tracked[c.key] = 1'b1;
                        r.ok = 1'b1;
                    end
                end
                ACT_EVICT: begin
                    // empty tracker: ok 0, victim 0
                    if (recency.size() > 0) begin
                        r.victim_key = recency.pop_front();
                        tracked[r.victim_key] = 1'b0;
                        r.ok = 1'b1;
                    end
                end
                ACT_ERASE: begin
                    if (tracked[c.key]) begin
                        unlink_key(c.key);
                        tracked[c.key] = 1'b0;
                        r.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            r.tracked_count = CNT_W'(recency.size());
            awaited.push_back(r);
        endfunction

        function void report(string what, t_res want, t_res got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected ok/victim/count %0b/%0d/%0d, got %0b/%0d/%0d",
                         $time, what, want.ok, want.victim_key, want.tracked_count,
                         got.ok, got.victim_key, got.tracked_count);
        endfunction

        // Compare a result word with the oldest one outstanding.
        function void check_res(t_res got);
            t_res want;
            if (awaited.size() == 0) begin
                report("unexpected result word", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.ok !== want.ok || got.victim_key !== want.victim_key ||
                    got.tracked_count !== want.tracked_count)
                report("result word mismatch", want, got);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block itself
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    lru_order_scoreboard order_sb = new();

    // sender burst state: words still to go back to back before a gap
    int burst_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lru_replacement_tracker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // ------------------------------------------------------------------
    // Monitor. Everything here is read at the rising edge, before any
    // update made at that edge lands. A command word is taken when start is
    // high and busy low; a result word is valid for the single cycle that
    // o_done is high and cannot be held off. The result is registered and
    // always trails its command, so noting first is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                order_sb.note_cmd(i_cmd);
            if (o_done)
                order_sb.check_res(o_res);
        end
    end

    // ------------------------------------------------------------------
    // Sender. Holds start with the word until the tracker takes it, then
    // either carries straight on (inside a burst) or drops start for a
    // random gap. During gaps i_cmd carries junk that must be ignored.
    // Random gaps land on every phase of an evict, erase or touch command,
    // bursts give back-to-back issue in the o_done cycle.
    // ------------------------------------------------------------------
    task automatic send_word(input t_cmd c);
        int gap;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 6);
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            i_cmd <= t_cmd'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic [1:0] act, input logic [KEY_W-1:0] k);
        t_cmd c;
        c.action = act;
        c.key    = k;
        send_word(c);
    endtask

    // Pick a random command word under the given weighting. Evict words
    // carry a random key too, since the key must be ignored there.
    function automatic t_cmd pick_word(int mix);
        t_cmd c;
        int   roll;
        roll  = $urandom_range(0, 99);
        c.key = KEY_W'($urandom);
        case (mix)
            MIX_FILL:
                c.action = (roll < 80) ? ACT_TOUCH :
                           (roll < 88) ? ACT_ERASE :
                           (roll < 96) ? ACT_EVICT : ACT_UNUSED;
            MIX_DRAIN:
                c.action = (roll < 50) ? ACT_EVICT :
                           (roll < 80) ? ACT_ERASE :
                           (roll < 95) ? ACT_TOUCH : ACT_UNUSED;
            default:
                c.action = (roll < 45) ? ACT_TOUCH :
                           (roll < 70) ? ACT_EVICT :
                           (roll < 95) ? ACT_ERASE : ACT_UNUSED;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int sent;
        int run_len;
        int mix;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: empty-tracker corners, both key extremes, moving a
        // tracked key, erasing tracked and untracked keys, the unused code.
        send(ACT_EVICT,  4'd0);     // evict with nothing tracked
        send(ACT_ERASE,  4'd15);    // erase of an untracked key
        send(ACT_UNUSED, 4'd15);    // unused action code
        send(ACT_TOUCH,  4'd0);
        send(ACT_TOUCH,  4'd15);
        send(ACT_TOUCH,  4'd7);
        send(ACT_TOUCH,  4'd0);     // already tracked: moves to most recent
        send(ACT_UNUSED, 4'd0);
        send(ACT_ERASE,  4'd15);    // tracked key at the least-recent end
        send(ACT_ERASE,  4'd15);    // now untracked
        send(ACT_EVICT,  4'd15);    // victim 7, key field ignored
        send(ACT_TOUCH,  4'd8);
        send(ACT_ERASE,  4'd8);     // erase of the most recent key
        send(ACT_EVICT,  4'd0);     // victim 0, tracker now empty
        send(ACT_EVICT,  4'd0);     // empty again
        send(ACT_ERASE,  4'd0);

        // Random: runs of one weighting at a time so the count swings from
        // empty to a full set of 16 and back, with every key in play.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            mix     = $urandom_range(MIX_FILL, MIX_BLEND);
            run_len = $urandom_range(20, 90);
            repeat (run_len) begin
                send_word(pick_word(mix));
                sent++;
            end
        end

        // Drain: wait for every outstanding word, then a few idle cycles to
        // catch any stray result.
        start <= 1'b0;
        while (order_sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (order_sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (up to about 1300 words, each
    // followed by its longest gap).
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
